@@ rtl/twrp_pkg.sv @@
// ============================================================================
// twrp_pkg
// Shared widths, codes and default sizes for the tiered weighted picker.
// ============================================================================
package twrp_pkg;

    // fixed field widths
    localparam int MODE_W      = 2;
    localparam int TIER_W      = 3;
    localparam int IN_WEIGHT_W = 8;
    localparam int MASK_W      = 16;
    localparam int RAND_W      = 16;
    localparam int STATUS_W    = 2;
    localparam int ENTRY_W     = 4;

    // default sizes
    localparam int DEF_MAX_ENTRIES = 16;
    localparam int DEF_MAX_TIERS   = 8;
    localparam int DEF_WEIGHT_BITS = 8;

    // request modes
    localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ADD    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SELECT = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NONE = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_TIER = 2'd3;

    // reset value of the tier limit
    localparam logic [TIER_W-1:0] HIGHEST_TIER_RST = 3'd7;

endpackage

@@ rtl/twrp_if.sv @@
// ============================================================================
// twrp_if
// Request and response channels of the tiered weighted picker.
// ============================================================================
interface twrp_req_if;
    logic                                  valid;
    logic                                  ready;
    logic [twrp_pkg::MODE_W-1:0]           mode;
    logic [twrp_pkg::TIER_W-1:0]           entry_tier;
    logic [twrp_pkg::IN_WEIGHT_W-1:0]      entry_weight;
    logic [twrp_pkg::MASK_W-1:0]           eligible_mask;
    logic [twrp_pkg::RAND_W-1:0]           random_value;

    modport source (
        output valid, mode, entry_tier, entry_weight, eligible_mask, random_value,
        input  ready
    );
    modport sink (
        input  valid, mode, entry_tier, entry_weight, eligible_mask, random_value,
        output ready
    );
endinterface

interface twrp_rsp_if;
    logic                                  valid;
    logic                                  ready;
    logic [twrp_pkg::STATUS_W-1:0]         status;
    logic [twrp_pkg::ENTRY_W-1:0]          selected_entry;
    logic [twrp_pkg::TIER_W-1:0]           selected_tier;

    modport source (
        output valid, status, selected_entry, selected_tier,
        input  ready
    );
    modport sink (
        input  valid, status, selected_entry, selected_tier,
        output ready
    );
endinterface

@@ rtl/twrp_table.sv @@
// ============================================================================
// twrp_table
// Entry table: tier and weight memories, one write and one registered read.
// ============================================================================
module twrp_table #(
    parameter int MAX_ENTRIES = twrp_pkg::DEF_MAX_ENTRIES,
    parameter int WEIGHT_BITS = twrp_pkg::DEF_WEIGHT_BITS
) (
    input  logic                                clk,
    input  logic                                wr_en,
    input  logic [$clog2(MAX_ENTRIES)-1:0]      wr_addr,
    input  logic [twrp_pkg::TIER_W-1:0]         wr_tier,
    input  logic [WEIGHT_BITS-1:0]              wr_weight,
    input  logic [$clog2(MAX_ENTRIES)-1:0]      rd_addr,
    output logic [twrp_pkg::TIER_W-1:0]         rd_tier,
    output logic [WEIGHT_BITS-1:0]              rd_weight
);

    logic [twrp_pkg::TIER_W-1:0] tier_mem   [MAX_ENTRIES];
    logic [WEIGHT_BITS-1:0]      weight_mem [MAX_ENTRIES];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            tier_mem[wr_addr]   <= wr_tier;
            weight_mem[wr_addr] <= wr_weight;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rd_tier   <= tier_mem[rd_addr];
        rd_weight <= weight_mem[rd_addr];
    end

endmodule

@@ rtl/tiered_weighted_random_picker.sv @@
// ============================================================================
// tiered_weighted_random_picker
// Keeps tiered weighted entries and picks one by lottery in the top tier.
// ============================================================================
// clear and add words: request to the finish state, then into the response register, then ready again
// select words: tier scan, then modulo, then pick walk over N = min(entries, 16) table entries
// the single add/subtract unit serves all three steps: one table entry per cycle in the
// tier scan and the pick walk, one remainder bit per cycle in the 16-step modulo
// one word in flight at a time; a finished response may wait while the next word
// is taken; reset empties the table and sets highest_tier to 7
module tiered_weighted_random_picker #(
    parameter int MAX_ENTRIES = twrp_pkg::DEF_MAX_ENTRIES,
    parameter int MAX_TIERS   = twrp_pkg::DEF_MAX_TIERS,
    parameter int WEIGHT_BITS = twrp_pkg::DEF_WEIGHT_BITS
) (
    input  logic                         clk,
    input  logic                         rst_n,
    twrp_req_if.sink                     req,
    twrp_rsp_if.source                   rsp,
    input  logic                         cfg_we,
    input  logic [twrp_pkg::TIER_W-1:0]  cfg_wdata
);

    localparam int AW  = $clog2(MAX_ENTRIES);
    localparam int CW  = $clog2(MAX_ENTRIES + 1);
    localparam int SW  = WEIGHT_BITS + twrp_pkg::ENTRY_W;
    localparam int XW  = SW + 1;
    localparam int IW  = twrp_pkg::ENTRY_W + 1;
    localparam int DCW = $clog2(twrp_pkg::RAND_W);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_DIV    = 3'd2;
    localparam logic [2:0] S_WALK   = 3'd3;
    localparam logic [2:0] S_FINISH = 3'd4;

    logic [2:0]                         state_reg, state_next;
    logic [CW-1:0]                      count_reg, count_next;
    logic [twrp_pkg::TIER_W-1:0]        hi_tier_reg;
    logic [twrp_pkg::MASK_W-1:0]        mask_reg, mask_next;
    logic [twrp_pkg::RAND_W-1:0]        dvd_reg, dvd_next;
    logic [IW-1:0]                      lim_reg, lim_next;
    logic [IW-1:0]                      idx_reg, idx_next;
    logic                               pend_reg, pend_next;
    logic [twrp_pkg::ENTRY_W-1:0]       pend_idx_reg, pend_idx_next;
    logic                               found_reg, found_next;
    logic [twrp_pkg::TIER_W-1:0]        best_tier_reg, best_tier_next;
    logic [SW-1:0]                      sum_reg, sum_next;
    logic [SW-1:0]                      rem_reg, rem_next;
    logic [DCW-1:0]                     div_cnt_reg, div_cnt_next;
    logic [twrp_pkg::STATUS_W-1:0]      res_status_reg, res_status_next;
    logic [twrp_pkg::ENTRY_W-1:0]       res_entry_reg, res_entry_next;
    logic [twrp_pkg::TIER_W-1:0]        res_tier_reg, res_tier_next;
    logic                               out_valid_reg;
    logic [twrp_pkg::STATUS_W-1:0]      out_status_reg;
    logic [twrp_pkg::ENTRY_W-1:0]       out_entry_reg;
    logic [twrp_pkg::TIER_W-1:0]        out_tier_reg;

    logic                               req_fire;
    logic                               out_load;
    logic                               tier_bad;
    logic                               table_full;
    logic                               wr_en;
    logic [twrp_pkg::TIER_W-1:0]        rd_tier;
    logic [WEIGHT_BITS-1:0]             rd_weight;
    logic                               pend_elig;
    logic                               issue;

    logic [XW-1:0]                      alu_a;
    logic [XW-1:0]                      alu_b;
    logic                               alu_sub;
    logic [XW:0]                        alu_res;
    logic                               alu_carry;

    // entry table
    twrp_table #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_table (
        .clk       (clk),
        .wr_en     (wr_en),
        .wr_addr   (AW'(count_reg)),
        .wr_tier   (req.entry_tier),
        .wr_weight (WEIGHT_BITS'(req.entry_weight)),
        .rd_addr   (AW'(idx_reg)),
        .rd_tier   (rd_tier),
        .rd_weight (rd_weight)
    );

    // handshake and add checks
    assign req.ready  = (state_reg == S_IDLE);
    assign req_fire   = req.valid && req.ready;
    assign out_load   = (state_reg == S_FINISH) && (!out_valid_reg || rsp.ready);
    assign tier_bad   = (req.entry_tier > hi_tier_reg) || (32'(req.entry_tier) >= MAX_TIERS);
    assign table_full = (32'(count_reg) >= MAX_ENTRIES);
    assign wr_en      = req_fire && (req.mode == twrp_pkg::MODE_ADD) && !tier_bad && !table_full;
    assign pend_elig  = pend_reg && mask_reg[pend_idx_reg];
    assign issue      = (idx_reg < lim_reg);

    // shared add/subtract unit
    always_comb
    begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
        unique case (state_reg)
            S_SCAN:
            begin
                alu_a = {1'b0, sum_reg};
                alu_b = XW'(rd_weight);
            end
            S_DIV:
            begin
                alu_a   = {rem_reg, dvd_reg[twrp_pkg::RAND_W-1]};
                alu_b   = {1'b0, sum_reg};
                alu_sub = 1'b1;
            end
            S_WALK:
            begin
                alu_a   = {1'b0, rem_reg};
                alu_b   = XW'(rd_weight);
                alu_sub = 1'b1;
            end
            default:
            begin
                alu_a = '0;
            end
        endcase
    end

    assign alu_res   = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)} + (XW+1)'(alu_sub);
    assign alu_carry = alu_res[XW];

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        mask_next       = mask_reg;
        dvd_next        = dvd_reg;
        lim_next        = lim_reg;
        idx_next        = idx_reg;
        pend_next       = pend_reg;
        pend_idx_next   = pend_idx_reg;
        found_next      = found_reg;
        best_tier_next  = best_tier_reg;
        sum_next        = sum_reg;
        rem_next        = rem_reg;
        div_cnt_next    = div_cnt_reg;
        res_status_next = res_status_reg;
        res_entry_next  = res_entry_reg;
        res_tier_next   = res_tier_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    res_status_next = twrp_pkg::STATUS_OK;
                    res_entry_next  = '0;
                    res_tier_next   = '0;
                    priority if (req.mode == twrp_pkg::MODE_CLEAR)
                    begin
                        count_next = '0;
                        state_next = S_FINISH;
                    end
                    else if (req.mode == twrp_pkg::MODE_ADD)
                    begin
                        priority if (tier_bad)
                        begin
                            res_status_next = twrp_pkg::STATUS_TIER;
                        end
                        else if (table_full)
                        begin
                            res_status_next = twrp_pkg::STATUS_FULL;
                        end
                        else
                        begin
                            res_entry_next = twrp_pkg::ENTRY_W'(count_reg);
                            res_tier_next  = req.entry_tier;
                            count_next     = count_reg + CW'(1);
                        end
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        mask_next  = req.eligible_mask;
                        dvd_next   = req.random_value;
                        lim_next   = (32'(count_reg) > twrp_pkg::MASK_W)
                                     ? IW'(twrp_pkg::MASK_W) : IW'(count_reg);
                        idx_next   = '0;
                        pend_next  = 1'b0;
                        found_next = 1'b0;
                        sum_next   = '0;
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                // find the top tier with weight and its total
                pend_next     = issue;
                pend_idx_next = twrp_pkg::ENTRY_W'(idx_reg);
                if (issue)
                begin
                    idx_next = idx_reg + IW'(1);
                end
                if (pend_elig && (rd_weight != '0))
                begin
                    if (!found_reg || (rd_tier > best_tier_reg))
                    begin
                        found_next     = 1'b1;
                        best_tier_next = rd_tier;
                        sum_next       = SW'(rd_weight);
                    end
                    else if (rd_tier == best_tier_reg)
                    begin
                        sum_next = alu_res[SW-1:0];
                    end
                end
                if (!issue && !pend_reg)
                begin
                    if (found_reg)
                    begin
                        rem_next     = '0;
                        div_cnt_next = '0;
                        state_next   = S_DIV;
                    end
                    else
                    begin
                        res_status_next = twrp_pkg::STATUS_NONE;
                        state_next      = S_FINISH;
                    end
                end
            end
            S_DIV:
            begin
                // restoring remainder, one bit per cycle
                rem_next     = alu_carry ? alu_res[SW-1:0] : alu_a[SW-1:0];
                dvd_next     = {dvd_reg[twrp_pkg::RAND_W-2:0], 1'b0};
                div_cnt_next = div_cnt_reg + DCW'(1);
                if (div_cnt_reg == DCW'(twrp_pkg::RAND_W - 1))
                begin
                    idx_next   = '0;
                    pend_next  = 1'b0;
                    state_next = S_WALK;
                end
            end
            S_WALK:
            begin
                // count the remainder down through the chosen tier
                pend_next     = issue;
                pend_idx_next = twrp_pkg::ENTRY_W'(idx_reg);
                if (issue)
                begin
                    idx_next = idx_reg + IW'(1);
                end
                if (pend_elig && (rd_tier == best_tier_reg))
                begin
                    if (!alu_carry)
                    begin
                        res_status_next = twrp_pkg::STATUS_OK;
                        res_entry_next  = pend_idx_reg;
                        res_tier_next   = best_tier_reg;
                        state_next      = S_FINISH;
                    end
                    else
                    begin
                        rem_next = alu_res[SW-1:0];
                    end
                end
                else if (!issue && !pend_reg)
                begin
                    res_status_next = twrp_pkg::STATUS_NONE;
                    state_next      = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            hi_tier_reg   <= twrp_pkg::HIGHEST_TIER_RST;
            pend_reg      <= 1'b0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            pend_reg  <= pend_next;
            found_reg <= found_next;
            if (cfg_we)
            begin
                hi_tier_reg <= cfg_wdata;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        mask_reg       <= mask_next;
        dvd_reg        <= dvd_next;
        lim_reg        <= lim_next;
        idx_reg        <= idx_next;
        pend_idx_reg   <= pend_idx_next;
        best_tier_reg  <= best_tier_next;
        sum_reg        <= sum_next;
        rem_reg        <= rem_next;
        div_cnt_reg    <= div_cnt_next;
        res_status_reg <= res_status_next;
        res_entry_reg  <= res_entry_next;
        res_tier_reg   <= res_tier_next;
        if (out_load)
        begin
            out_status_reg <= res_status_reg;
            out_entry_reg  <= res_entry_reg;
            out_tier_reg   <= res_tier_reg;
        end
    end

    // response channel
    assign rsp.valid          = out_valid_reg;
    assign rsp.status         = out_status_reg;
    assign rsp.selected_entry = out_entry_reg;
    assign rsp.selected_tier  = out_tier_reg;

endmodule

@@ rtl/twrp_checker.sv @@
// ============================================================================
// twrp_checker
// Port-level checks for the tiered weighted picker, bound to the top level.
// ============================================================================
module twrp_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             req_valid,
    input  logic                             req_ready,
    input  logic [twrp_pkg::MODE_W-1:0]      req_mode,
    input  logic                             rsp_valid,
    input  logic                             rsp_ready,
    input  logic [twrp_pkg::STATUS_W-1:0]    rsp_status,
    input  logic [twrp_pkg::ENTRY_W-1:0]     rsp_entry,
    input  logic [twrp_pkg::TIER_W-1:0]      rsp_tier
);

    // a stalled response word stays up
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=> rsp_valid)
        else $error("response dropped while stalled");

    // a stalled response word keeps its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=>
            ($stable(rsp_status) && $stable(rsp_entry) && $stable(rsp_tier)))
        else $error("response payload changed while stalled");

    // a select word keeps the block busy on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready && (req_mode != twrp_pkg::MODE_CLEAR)
            && (req_mode != twrp_pkg::MODE_ADD)) |=> !req_ready)
        else $error("request taken during a select");

    // clear and add reach the response register by way of the finish state when the output is free
    assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready && !rsp_valid
            && ((req_mode == twrp_pkg::MODE_CLEAR) || (req_mode == twrp_pkg::MODE_ADD)))
            |=> ##1 rsp_valid)
        else $error("clear or add response late");

endmodule

bind tiered_weighted_random_picker twrp_checker u_twrp_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (req.valid),
    .req_ready  (req.ready),
    .req_mode   (req.mode),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .rsp_status (rsp.status),
    .rsp_entry  (rsp.selected_entry),
    .rsp_tier   (rsp.selected_tier)
);
